[sv/wim_pkg.sv]
// ----------------------------------------------------------------------------
// wim_pkg
// Shared types, constants and IUPAC matching for the windowed mismatch block.
// ----------------------------------------------------------------------------
package wim_pkg;

	localparam int BASE_W   = 8;
	localparam int CFG_W    = 9;
	localparam int COUNT_W  = 9;
	localparam int PCT_W    = 15;
	localparam int CENTRE_W = 25;
	localparam int STEP_W   = 8;
	localparam int IDX_W    = 1;

	localparam logic [IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [IDX_W-1:0] REG_WINDOW_STEP = 1'b1;

	localparam logic [CFG_W-1:0] SIZE_RESET = 9'd64;
	localparam logic [CFG_W-1:0] STEP_RESET = 9'd16;
	localparam logic [CFG_W-1:0] STEP_LIMIT = 9'd256;

	localparam logic [BASE_W-1:0] DOT_CHAR = 8'h2E;
	localparam logic [BASE_W-1:0] CHAR_U   = 8'h55;
	localparam logic [BASE_W-1:0] CHAR_T   = 8'h54;
	localparam logic [BASE_W-1:0] CHAR_N   = 8'h4E;

	localparam int PERCENT_SCALE = 100;
	localparam logic [PCT_W-1:0] Q8_PERCENT = PCT_W'(PERCENT_SCALE * 256);
	localparam logic [PCT_W-1:0] PCT_MAX    = PCT_W'(PERCENT_SCALE * 256);
	localparam logic [CENTRE_W-1:0] CENTRE_MAX = '1;

	typedef struct packed {
		logic capture;
		logic update;
		logic mul;
		logic div_step;
		logic load_out;
	} wim_cmd_t;

	typedef struct packed {
		logic emit;
		logic div_last;
		logic out_busy;
	} wim_stat_t;

	function automatic logic [BASE_W-1:0] normalize(input logic [BASE_W-1:0] c);
		logic [BASE_W-1:0] u;
		u = c;
		if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
		if (u == CHAR_U) u = CHAR_T;
		return u;
	endfunction

	function automatic logic [3:0] base_set(input logic [BASE_W-1:0] c);
		logic [3:0] m;
		case (c)
			8'h41:   m = 4'd1;
			8'h43:   m = 4'd2;
			8'h47:   m = 4'd4;
			8'h54:   m = 4'd8;
			8'h52:   m = 4'd5;
			8'h59:   m = 4'd10;
			8'h53:   m = 4'd6;
			8'h57:   m = 4'd9;
			8'h4B:   m = 4'd12;
			8'h4D:   m = 4'd3;
			8'h42:   m = 4'd14;
			8'h44:   m = 4'd13;
			8'h48:   m = 4'd11;
			8'h56:   m = 4'd7;
			CHAR_N:  m = 4'd15;
			default: m = 4'd0;
		endcase
		return m;
	endfunction

	function automatic logic chars_match(input logic [BASE_W-1:0] a,
	                                     input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] na;
		logic [BASE_W-1:0] nb;
		logic [3:0] ma;
		logic [3:0] mb;
		logic single;
		na = normalize(a);
		nb = normalize(b);
		ma = base_set(na);
		mb = base_set(nb);
		single = ($countones(ma) == 1) || ($countones(mb) == 1);
		if (na == nb) return 1'b1;
		if (ma == 4'd0 || mb == 4'd0) return 1'b0;
		if (ma == 4'd15 || mb == 4'd15) return 1'b1;
		return single && ((ma & mb) != 4'd0);
	endfunction

endpackage

[sv/wim_in_if.sv]
// ----------------------------------------------------------------------------
// wim_in_if
// Input channel: one aligned pair of sequence characters per word.
// ----------------------------------------------------------------------------
interface wim_in_if
	import wim_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BASE_W-1:0] base_first;
	logic [BASE_W-1:0] base_second;
	logic              final_position;

	modport source (output valid, output base_first, output base_second,
	                output final_position, input ready);
	modport sink   (input valid, input base_first, input base_second,
	                input final_position, output ready);
endinterface

[sv/wim_out_if.sv]
// ----------------------------------------------------------------------------
// wim_out_if
// Result channel: one word per completed window.
// ----------------------------------------------------------------------------
interface wim_out_if
	import wim_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [COUNT_W-1:0]  mismatch_count;
	logic [COUNT_W-1:0]  counted_positions;
	logic [PCT_W-1:0]    percent_q8;
	logic                none_counted;
	logic [CENTRE_W-1:0] centre_doubled;

	modport source (output valid, output mismatch_count, output counted_positions,
	                output percent_q8, output none_counted, output centre_doubled,
	                input ready);
	modport sink   (input valid, input mismatch_count, input counted_positions,
	                input percent_q8, input none_counted, input centre_doubled,
	                output ready);
endinterface

[sv/windowed_iupac_mismatch.sv]
// ----------------------------------------------------------------------------
// windowed_iupac_mismatch
// Sliding-window IUPAC mismatch count and Q8 percentage over a base pair stream.
// ----------------------------------------------------------------------------
// Usage:
//   pairs   : one word per aligned position (two ASCII bases, final flag).
//   results : one word per completed window (counts, Q8 percent, centre x2).
//   cfg_*   : write the window length (index 0) and the window stride
//             (index 1) while idle.
// Sequence:
//   A word that emits no result is accepted, then the flag ring is
//   updated (ring RAM read of the leaving entry is registered).
//   A word that emits a result goes through these steps to the output
//   register: accept, update, the x25600 scale, the restoring divider
//   (one quotient bit a cycle), then the load.
//   The next pair is accepted as soon as the result sits in the output
//   register; a stalled receiver holds the block only when a newer result
//   is ready to load.
// Reset: run state clears, window length 64, stride 16. The ring RAM is
//   not cleared; an entry is always written before it leaves the window.
// A set final_position ends the run; a window result due at it is still produced.
// ----------------------------------------------------------------------------
module windowed_iupac_mismatch
	import wim_pkg::*;
#(
	parameter int MAX_WINDOW    = 256,
	parameter int POSITION_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	wim_in_if.sink           pairs,
	wim_out_if.source        results
);
	wim_cmd_t  cmd;
	wim_stat_t stat;

	wim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pairs.valid),
		.in_ready (pairs.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wim_datapath #(
		.MAX_WINDOW    (MAX_WINDOW),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.base_first     (pairs.base_first),
		.base_second    (pairs.base_second),
		.final_position (pairs.final_position),
		.res            (results)
	);
endmodule

[sv/wim_ram.sv]
// ----------------------------------------------------------------------------
// wim_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wim_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

[sv/wim_ctrl.sv]
// ----------------------------------------------------------------------------
// wim_ctrl
// Sequencer: accept, ring update; on emit, scale, divide, hand to output reg.
// ----------------------------------------------------------------------------
module wim_ctrl
	import wim_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  wim_stat_t stat,
	output wim_cmd_t  cmd
);
	typedef enum logic [2:0] {S_IDLE, S_UPD, S_MUL, S_DIV, S_OUT} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_UPD;
				S_UPD:  state_q <= stat.emit ? S_MUL : S_IDLE;
				S_MUL:  state_q <= S_DIV;
				S_DIV:  if (stat.div_last) state_q <= S_OUT;
				S_OUT:  if (!stat.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready     = (state_q == S_IDLE);
		cmd.capture  = in_ready && in_valid;
		cmd.update   = (state_q == S_UPD);
		cmd.mul      = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.load_out = (state_q == S_OUT) && !stat.out_busy;
	end

	a_capture_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.update)
		else $error("accepted word not followed by ring update");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && !stat.emit) |=> in_ready)
		else $error("not ready after word without result");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && stat.div_last) |=> state_q == S_OUT)
		else $error("divide end did not reach output");
endmodule

[sv/wim_datapath.sv]
// ----------------------------------------------------------------------------
// wim_datapath
// Flag ring, running sums, window step, Q8 percent divider and output reg.
// ----------------------------------------------------------------------------
module wim_datapath
	import wim_pkg::*;
#(
	parameter int MAX_WINDOW    = 256,
	parameter int POSITION_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wim_cmd_t          cmd,
	output wim_stat_t         stat,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [BASE_W-1:0] base_first,
	input  logic [BASE_W-1:0] base_second,
	input  logic              final_position,
	wim_out_if.source         res
);
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int SUM_W = $clog2(MAX_WINDOW + 1);
	localparam int CW    = (SUM_W > CFG_W) ? SUM_W : CFG_W;
	localparam int XW    = ((POSITION_BITS > SUM_W) ? POSITION_BITS : SUM_W) + 2;
	localparam int CXW   = (XW > CENTRE_W) ? XW : CENTRE_W;
	localparam int NW    = SUM_W + PCT_W;
	localparam int QB    = $clog2(PCT_W);

	logic [CFG_W-1:0]         size_cfg_q;
	logic [CFG_W-1:0]         step_cfg_q;
	logic [PTR_W-1:0]         ptr_q;
	logic [SUM_W-1:0]         msum_q;
	logic [SUM_W-1:0]         csum_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [STEP_W-1:0]        cdown_q;
	logic [QB-1:0]            dcnt_q;
	logic                     out_valid_q;

	logic                     counted_s1;
	logic                     mis_s1;
	logic                     fin_s1;

	logic [SUM_W-1:0]         res_m_q;
	logic [SUM_W-1:0]         res_c_q;
	logic                     res_none_q;
	logic [CENTRE_W-1:0]      res_centre_q;
	logic [NW-1:0]            rem_q;
	logic [PCT_W-1:0]         quot_q;

	logic [COUNT_W-1:0]       out_m_q;
	logic [COUNT_W-1:0]       out_c_q;
	logic [PCT_W-1:0]         out_pct_q;
	logic                     out_none_q;
	logic [CENTRE_W-1:0]      out_centre_q;

	logic [SUM_W-1:0]         size_eff;
	logic [CFG_W-1:0]         step_eff;
	logic [STEP_W-1:0]        step_m1;
	logic [PTR_W-1:0]         old_idx;
	logic [SUM_W:0]           ptr_x;
	logic [SUM_W:0]           sz_x;
	logic [1:0]               old_flags;
	logic                     counted_in;
	logic                     mis_in;

	logic [XW-1:0]            pos_x;
	logic [XW-1:0]            size_x;
	logic [XW-1:0]            centre_x;
	logic [CXW-1:0]           centre_c;
	logic [CENTRE_W-1:0]      centre_sat;
	logic                     p_ge;
	logic                     win;
	logic                     emit;
	logic [SUM_W-1:0]         csum_dec;
	logic [SUM_W-1:0]         msum_dec;
	logic [SUM_W-1:0]         csum_nx;
	logic [SUM_W-1:0]         msum_nx;
	logic [PTR_W-1:0]         ptr_nx;
	logic [NW-1:0]            dsh;

	always_comb begin
		if (size_cfg_q == '0) size_eff = SUM_W'(1);
		else if (CW'(size_cfg_q) > CW'(MAX_WINDOW)) size_eff = SUM_W'(MAX_WINDOW);
		else size_eff = SUM_W'(size_cfg_q);

		if (step_cfg_q == '0) step_eff = CFG_W'(1);
		else if (step_cfg_q > STEP_LIMIT) step_eff = STEP_LIMIT;
		else step_eff = step_cfg_q;
		step_m1 = STEP_W'(step_eff - CFG_W'(1));

		ptr_x = (SUM_W+1)'(ptr_q);
		sz_x  = (SUM_W+1)'(size_eff);
		if (ptr_x >= sz_x) old_idx = PTR_W'(ptr_x - sz_x);
		else old_idx = PTR_W'(ptr_x + (SUM_W+1)'(MAX_WINDOW) - sz_x);

		counted_in = (base_first != DOT_CHAR) && (base_second != DOT_CHAR);
		mis_in     = counted_in && !chars_match(base_first, base_second);

		pos_x    = XW'(pos_q);
		size_x   = XW'(size_eff);
		p_ge     = pos_x >= size_x;
		win      = (pos_x + XW'(1)) >= size_x;
		emit     = win && (cdown_q == '0);
		centre_x = (pos_x << 1) + XW'(3) - size_x;
		centre_c = CXW'(centre_x);
		centre_sat = (centre_c > CXW'(CENTRE_MAX)) ? CENTRE_MAX : CENTRE_W'(centre_c);

		csum_dec = (p_ge && old_flags[0] && csum_q != '0) ? csum_q - SUM_W'(1) : csum_q;
		msum_dec = (p_ge && old_flags[1] && msum_q != '0) ? msum_q - SUM_W'(1) : msum_q;
		csum_nx  = (counted_s1 && csum_dec < SUM_W'(MAX_WINDOW)) ?
		           csum_dec + SUM_W'(1) : csum_dec;
		msum_nx  = (mis_s1 && msum_dec < SUM_W'(MAX_WINDOW)) ?
		           msum_dec + SUM_W'(1) : msum_dec;
		ptr_nx   = (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + PTR_W'(1);

		dsh = NW'(res_c_q) << dcnt_q;

		stat.emit     = emit;
		stat.div_last = (dcnt_q == '0);
		stat.out_busy = out_valid_q && !res.ready;
	end

	wim_ram #(.WIDTH(2), .DEPTH(MAX_WINDOW)) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (ptr_q),
		.wdata ({mis_s1, counted_s1}),
		.re    (cmd.capture),
		.raddr (old_idx),
		.rdata (old_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q  <= SIZE_RESET;
			step_cfg_q  <= STEP_RESET;
			ptr_q       <= '0;
			msum_q      <= '0;
			csum_q      <= '0;
			pos_q       <= '0;
			cdown_q     <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_SIZE: size_cfg_q <= cfg_data;
					REG_WINDOW_STEP: step_cfg_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.update) begin
				if (fin_s1) begin
					ptr_q   <= '0;
					msum_q  <= '0;
					csum_q  <= '0;
					pos_q   <= '0;
					cdown_q <= '0;
				end else begin
					ptr_q  <= ptr_nx;
					msum_q <= msum_nx;
					csum_q <= csum_nx;
					if (pos_q != '1) pos_q <= pos_q + POSITION_BITS'(1);
					if (win) cdown_q <= emit ? step_m1 : cdown_q - STEP_W'(1);
				end
			end
			if (cmd.mul) dcnt_q <= QB'(PCT_W - 1);
			else if (cmd.div_step && dcnt_q != '0) dcnt_q <= dcnt_q - QB'(1);
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			counted_s1 <= counted_in;
			mis_s1     <= mis_in;
			fin_s1     <= final_position;
		end
		if (cmd.update && emit) begin
			res_m_q      <= msum_nx;
			res_c_q      <= csum_nx;
			res_none_q   <= (csum_nx == '0);
			res_centre_q <= centre_sat;
		end
		if (cmd.mul) begin
			rem_q  <= NW'(res_m_q) * NW'(Q8_PERCENT);
			quot_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_q >= dsh) begin
				rem_q          <= rem_q - dsh;
				quot_q[dcnt_q] <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_m_q      <= COUNT_W'(res_m_q);
			out_c_q      <= COUNT_W'(res_c_q);
			out_none_q   <= res_none_q;
			out_centre_q <= res_centre_q;
			if (res_none_q) out_pct_q <= '0;
			else if (res_m_q > res_c_q) out_pct_q <= PCT_MAX;
			else out_pct_q <= quot_q;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.mismatch_count    = out_m_q;
	assign res.counted_positions = out_c_q;
	assign res.percent_q8        = out_pct_q;
	assign res.none_counted      = out_none_q;
	assign res.centre_doubled    = out_centre_q;

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(csum_q <= SUM_W'(MAX_WINDOW)) && (msum_q <= SUM_W'(MAX_WINDOW)))
		else $error("running sum above window depth");

	a_final_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && fin_s1) |=> (ptr_q == '0) && (pos_q == '0) && (cdown_q == '0))
		else $error("run state not cleared after final position");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> res.valid && (!res.none_counted || res.percent_q8 == '0))
		else $error("bad result word after load");
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_iupac_mismatch. Streams aligned base pairs
// through the pair channel under several window settings and idle patterns,
// predicts every window word in step with accepted pairs, and compares each
// result word field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import wim_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH     = 256;
	localparam int POS_BITS       = 24;
	localparam int SETTLE_CYCLES  = 30;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 12;
	localparam int SQUEEZE_PHASE  = 4;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [BASE_W-1:0] base_a;
		logic [BASE_W-1:0] base_b;
		logic              final_pos;
	} pair_word_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  mismatches;
		logic [COUNT_W-1:0]  counted;
		logic [PCT_W-1:0]    pct;
		logic                none;
		logic [CENTRE_W-1:0] centre;
	} window_word_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	wim_in_if  pairs();
	wim_out_if results();

	windowed_iupac_mismatch #(
		.MAX_WINDOW    (RING_DEPTH),
		.POSITION_BITS (POS_BITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pairs     (pairs),
		.results   (results)
	);

	always #5 clk = ~clk;

	pair_word_t   pairs_to_send[$];
	window_word_t windows_due[$];
	pair_word_t   next_word;
	window_word_t got, want;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned fault_count;
	int unsigned quiet_cycles;
	int unsigned hold_left;
	bit          squeeze_req;
	bit          squeeze_taken;

	// predictor state
	logic [1:0]          flag_mem [RING_DEPTH];
	logic [7:0]          ring_ptr;
	logic [COUNT_W-1:0]  mis_sum;
	logic [COUNT_W-1:0]  cnt_sum;
	logic [POS_BITS-1:0] pos_count;
	logic [STEP_W-1:0]   countdown;
	logic [CFG_W-1:0]    size_reg;
	logic [CFG_W-1:0]    step_reg;
	bit                  ring_full;

	string code_pool = "ACGTACGTACGTURYSWKMBDHVN";

	function automatic logic [3:0] code_bases(input logic [7:0] c);
		case (c)
			"A": return 4'b0001;
			"C": return 4'b0010;
			"G": return 4'b0100;
			"T": return 4'b1000;
			"R": return 4'b0101;
			"Y": return 4'b1010;
			"S": return 4'b0110;
			"W": return 4'b1001;
			"K": return 4'b1100;
			"M": return 4'b0011;
			"B": return 4'b1110;
			"D": return 4'b1101;
			"H": return 4'b1011;
			"V": return 4'b0111;
			"N": return 4'b1111;
			default: return 4'b0000;
		endcase
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] u;
		u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		return (u == "U") ? "T" : u;
	endfunction

	function automatic bit bases_agree(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] fa, fb;
		logic [3:0] sa, sb;
		bit plain;
		fa = fold_case(a);
		fb = fold_case(b);
		sa = code_bases(fa);
		sb = code_bases(fb);
		plain = (sa != 0 && (sa & (sa - 4'd1)) == 0) || (sb != 0 && (sb & (sb - 4'd1)) == 0);
		if (fa == fb)
			return 1'b1;
		if (sa == 0 || sb == 0)
			return 1'b0;
		if (sa == 4'b1111 || sb == 4'b1111)
			return 1'b1;
		return plain && ((sa & sb) != 0);
	endfunction

	function automatic void clear_run();
		ring_ptr  = '0;
		mis_sum   = '0;
		cnt_sum   = '0;
		pos_count = '0;
		countdown = '0;
	endfunction

	task automatic predict_window(input pair_word_t w);
		int unsigned  size, step, pct;
		longint unsigned centre;
		bit           counted, mis;
		logic [1:0]   leaving;
		window_word_t r;
		size = (size_reg == 0) ? 1 : (size_reg > RING_DEPTH) ? RING_DEPTH : size_reg;
		step = (step_reg == 0) ? 1 : (step_reg > STEP_LIMIT) ? STEP_LIMIT : step_reg;
		counted = (w.base_a != DOT_CHAR) && (w.base_b != DOT_CHAR);
		mis = counted && !bases_agree(w.base_a, w.base_b);
		if (pos_count >= size) begin
			leaving = flag_mem[8'(ring_ptr - 8'(size))];
			if (leaving[0] && cnt_sum != 0)
				cnt_sum--;
			if (leaving[1] && mis_sum != 0)
				mis_sum--;
		end
		flag_mem[ring_ptr] = {mis, counted};
		if (counted && cnt_sum < RING_DEPTH)
			cnt_sum++;
		if (mis && mis_sum < RING_DEPTH)
			mis_sum++;
		ring_ptr++;
		if (ring_ptr == 0)
			ring_full = 1'b1;
		if (32'(pos_count) + 1 >= size) begin
			if (countdown == 0) begin
				pct = 0;
				if (cnt_sum != 0) begin
					pct = (32'(mis_sum) * PERCENT_SCALE * 256) / cnt_sum;
					if (pct > PCT_MAX)
						pct = PCT_MAX;
				end
				centre = 64'(pos_count) * 2 + 3 - size;
				if (centre > 64'(CENTRE_MAX))
					centre = 64'(CENTRE_MAX);
				r.mismatches = mis_sum;
				r.counted    = cnt_sum;
				r.pct        = PCT_W'(pct);
				r.none       = (cnt_sum == 0);
				r.centre     = CENTRE_W'(centre);
				windows_due.push_back(r);
				countdown = STEP_W'(step - 1);
			end else begin
				countdown--;
			end
		end
		if (pos_count != '1)
			pos_count++;
		if (w.final_pos)
			clear_run();
	endtask

	task automatic note_error(input string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// pair driver, register write tracking and prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs.valid          <= 1'b0;
			pairs.base_first     <= '0;
			pairs.base_second    <= '0;
			pairs.final_position <= 1'b0;
			clear_run();
			size_reg  = SIZE_RESET;
			step_reg  = STEP_RESET;
			ring_full = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_SIZE: size_reg = cfg_data;
					REG_WINDOW_STEP: step_reg = cfg_data;
					default: ;
				endcase
			end
			if (pairs.valid && pairs.ready)
				predict_window({pairs.base_first, pairs.base_second, pairs.final_position});
			if (!pairs.valid || pairs.ready) begin
				if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_word = pairs_to_send.pop_front();
					pairs.valid          <= 1'b1;
					pairs.base_first     <= next_word.base_a;
					pairs.base_second    <= next_word.base_b;
					pairs.final_position <= next_word.final_pos;
				end else begin
					pairs.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, started once by the stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left     <= 0;
			squeeze_taken <= 1'b0;
		end else if (squeeze_req && !squeeze_taken) begin
			squeeze_taken <= 1'b1;
			hold_left     <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				got = {results.mismatch_count, results.counted_positions, results.percent_q8,
				       results.none_counted, results.centre_doubled};
				if (windows_due.size() == 0) begin
					note_error($sformatf("unexpected word: mis %0d cnt %0d pct %0d none %0b ctr %0d",
						got.mismatches, got.counted, got.pct, got.none, got.centre));
				end else begin
					want = windows_due.pop_front();
					if (got.mismatches !== want.mismatches || got.counted !== want.counted ||
					    got.pct !== want.pct || got.none !== want.none ||
					    got.centre !== want.centre)
						note_error($sformatf({"word mismatch: expected mis %0d cnt %0d pct %0d ",
							"none %0b ctr %0d, got mis %0d cnt %0d pct %0d none %0b ctr %0d"},
							want.mismatches, want.counted, want.pct, want.none, want.centre,
							got.mismatches, got.counted, got.pct, got.none, got.centre));
				end
			end
			results.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((pairs.valid && pairs.ready) || (results.valid && results.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("[windowed_iupac_mismatch] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_base();
		int unsigned r;
		logic [7:0] c;
		r = $urandom_range(99);
		if (r < 8) begin
			c = DOT_CHAR;
		end else if (r < 16) begin
			c = 8'($urandom_range(255));
		end else begin
			c = code_pool[$urandom_range(code_pool.len() - 1)];
			if ($urandom_range(3) == 0)
				c = c | 8'h20;
		end
		return c;
	endfunction

	task automatic push_pair(input logic [7:0] a, input logic [7:0] b, input bit fin);
		pair_word_t w;
		w.base_a    = a;
		w.base_b    = b;
		w.final_pos = fin;
		pairs_to_send.push_back(w);
	endtask

	task automatic queue_run(input int unsigned len, input bit close, input int unsigned noise);
		logic [7:0] a;
		for (int unsigned i = 0; i < len; i++) begin
			a = pick_base();
			push_pair(a, ($urandom_range(99) < noise) ? pick_base() : a, close && i == len - 1);
		end
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pairs_to_send.size() != 0 || pairs.valid || windows_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	int unsigned ph_size   [NUM_PHASES] = '{511, 8, 1, 32, 5, 64, 256, 0, 2, 17, 257, 3};
	int unsigned ph_step   [NUM_PHASES] = '{511, 1, 1, 8, 3, 300, 1, 0, 256, 5, 20, 2};
	int unsigned ph_budget [NUM_PHASES] = '{300, 100, 80, 100, 100, 100, 270, 60, 60, 80, 80, 60};

	initial begin
		int unsigned eff, left, len;
		bit          close;
		idle_mode_t  mode;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_WINDOW_SIZE;
		cfg_data             = '0;
		pairs.valid          = 1'b0;
		pairs.base_first     = '0;
		pairs.base_second    = '0;
		pairs.final_position = 1'b0;
		results.ready        = 1'b0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		fault_count          = 0;
		squeeze_req          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// one window per pair: matching rules one at a time
		write_reg(REG_WINDOW_SIZE, '0);
		write_reg(REG_WINDOW_STEP, '0);
		@(negedge clk);
		push_pair(8'h00, 8'hFF, 1'b0);
		push_pair(".", "A", 1'b0);
		push_pair("A", ".", 1'b0);
		push_pair(".", ".", 1'b0);
		push_pair("a", "A", 1'b0);
		push_pair("U", "t", 1'b0);
		push_pair("u", "T", 1'b0);
		push_pair("N", "R", 1'b0);
		push_pair("R", "n", 1'b0);
		push_pair("R", "S", 1'b0);
		push_pair("R", "R", 1'b0);
		push_pair("A", "R", 1'b0);
		push_pair("G", "S", 1'b0);
		push_pair("G", "Y", 1'b0);
		push_pair("g", "k", 1'b0);
		push_pair("B", "G", 1'b0);
		push_pair("C", "D", 1'b0);
		push_pair("X", "X", 1'b0);
		push_pair("X", "N", 1'b0);
		push_pair(8'hFF, 8'hFF, 1'b1);
		settle();

		// a window of dots only, then a counted one
		write_reg(REG_WINDOW_SIZE, 9'd3);
		write_reg(REG_WINDOW_STEP, 9'd2);
		@(negedge clk);
		push_pair(".", "C", 1'b0);
		push_pair(".", ".", 1'b0);
		push_pair("T", ".", 1'b0);
		push_pair("A", "C", 1'b0);
		push_pair("G", "G", 1'b1);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			write_reg(REG_WINDOW_SIZE, CFG_W'(ph_size[ph]));
			write_reg(REG_WINDOW_STEP, CFG_W'(ph_step[ph]));
			@(negedge clk);
			mode = idle_mode_t'(ph % 4);
			case (mode)
				IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				IDLE_SENDER:   begin send_idle_pct = 76; recv_stall_pct = 0;  end
				IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default:       begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			eff = (ph_size[ph] == 0) ? 1 : (ph_size[ph] > RING_DEPTH) ? RING_DEPTH : ph_size[ph];
			left = ph_budget[ph];
			while (left > 0) begin
				if (ph == 0)
					len = left;
				else if ($urandom_range(6) == 0)
					len = $urandom_range(eff, 1);
				else
					len = $urandom_range(2 * eff + 12, eff);
				if (len > left)
					len = left;
				// the last run of a setting may stay open into the next one, but only once every ring entry holds data
				close = (len < left) || !ring_full || ($urandom_range(1) == 0);
				queue_run(len, close, $urandom_range(60));
				left -= len;
			end
			if (ph == SQUEEZE_PHASE)
				squeeze_req = 1'b1;
		end

		settle();
		if (fault_count == 0)
			$display("[windowed_iupac_mismatch] OK");
		else
			$display("[windowed_iupac_mismatch] ERROR");
		$finish;
	end

endmodule
